// ----- design/wvs_pkg.sv -----
// shared types and constants for the weighted volume selector
package wvs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int WEIGHT_BITS = 32;
    localparam int RAND_BITS   = 16;
    localparam int SUM_W       = 38;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PROD_W      = SUM_W + RAND_BITS;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - SUM_W;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_PICK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [WEIGHT_BITS-1:0] wdata;
        logic [IDX_W-1:0]       raddr;
    } t_tbl_cmd;

endpackage

// ----- design/weighted_volume_selector.sv -----
// weighted volume selector top level: roulette wheel pick over a weight table
//
// channel   dir  tdata (low bit up)                      tuser
// s_axis    in   weight[31:0], rand_frac[47:32]          req_type[0]
// m_axis    out  entry_index[5:0], total_weight[43:6]    status[1:0]
//
// add, empty pick and single entry pick: result register, then output register
// pick over more entries: scan from index 0 up to k, one table read per scan cycle
// through the single table read port, then result register and output register
// one request at a time; a new request is taken while a result waits
// reset clears entry count, total and output valid; the table is not cleared
module weighted_volume_selector import wvs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // weight, rand_frac
    input  logic [0:0]             s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // entry_index, total_weight, zero pad
    output logic [1:0]             m_axis_tuser    // status
);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [SUM_W-1:0]       r_sel, n_sel;
    logic [SUM_W:0]         r_acc, n_acc;
    logic [IDX_W-1:0]       r_idx, n_idx;
    t_status                r_res_status, n_res_status;
    logic [IDX_W-1:0]       r_res_index, n_res_index;
    logic [SUM_W-1:0]       r_res_total, n_res_total;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [IDX_W-1:0]       r_out_index, n_out_index;
    logic [SUM_W-1:0]       r_out_total, n_out_total;

    t_tbl_cmd               w_cmd;
    logic [WEIGHT_BITS-1:0] w_rd_data;
    logic                   w_accept;
    logic                   w_req;
    logic [WEIGHT_BITS-1:0] w_weight;
    logic [RAND_BITS-1:0]   w_rand;
    logic [PROD_W-1:0]      w_prod;
    logic [SUM_W:0]         w_add_sum;
    logic [SUM_W-1:0]       w_add_sat;
    logic [SUM_W:0]         w_acc_next;
    logic                   w_hit;

    wvs_table u_table (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .o_rd_data (w_rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_req         = s_axis_tuser[0];
    assign w_weight      = s_axis_tdata[WEIGHT_BITS-1:0];
    assign w_rand        = s_axis_tdata[WEIGHT_BITS +: RAND_BITS];

    assign w_prod     = PROD_W'(r_sum) * PROD_W'(w_rand);
    assign w_add_sum  = {1'b0, r_sum} + (SUM_W+1)'(w_weight);
    assign w_add_sat  = w_add_sum[SUM_W] ? {SUM_W{1'b1}} : w_add_sum[SUM_W-1:0];
    assign w_acc_next = r_acc + (SUM_W+1)'(w_rd_data);
    assign w_hit      = ({1'b0, r_sel} < w_acc_next)
                     || (CNT_W'(r_idx) == r_count - CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sum        = r_sum;
        n_sel        = r_sel;
        n_acc        = r_acc;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_total  = r_res_total;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_total  = r_out_total;
        w_cmd.we     = 1'b0;
        w_cmd.waddr  = r_count[IDX_W-1:0];
        w_cmd.wdata  = w_weight;
        w_cmd.raddr  = (r_state == S_SCAN) ? r_idx + IDX_W'(1) : '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state      = S_DONE;
                    n_res_status = ST_OK;
                    n_res_index  = '0;
                    n_res_total  = r_sum;
                    if (w_req == REQ_ADD) begin
                        if (r_count == CNT_W'(MAX_ENTRIES)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_cmd.we    = 1'b1;
                            n_count     = r_count + CNT_W'(1);
                            n_sum       = w_add_sat;
                            n_res_index = r_count[IDX_W-1:0];
                            n_res_total = w_add_sat;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = ST_EMPTY;
                    end else if (r_count != CNT_W'(1)) begin
                        n_sel   = w_prod[PROD_W-1:RAND_BITS];
                        n_acc   = '0;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res_status = ST_OK;
                    n_res_index  = r_idx;
                    n_res_total  = r_sum;
                    n_state      = S_DONE;
                end else begin
                    n_acc = w_acc_next;
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_out_total  = r_res_total;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_acc        <= n_acc;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_total  <= n_res_total;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_total  <= n_out_total;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_total, r_out_index};
    assign m_axis_tuser  = r_out_status;

endmodule

// ----- design/wvs_table.sv -----
// weight table memory with one write port and a registered read port
module wvs_table import wvs_pkg::*; (
    input  logic                   i_clk,
    input  t_tbl_cmd               i_cmd,
    output logic [WEIGHT_BITS-1:0] o_rd_data
);

    logic [WEIGHT_BITS-1:0] r_mem [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rd_data <= r_mem[i_cmd.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/wvs_checker.sv -----
// port level checks for the weighted volume selector and their binding
module wvs_checker import wvs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [0:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

    // error results carry index zero
    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[IDX_W-1:0] == '0)
        else $error("error result with nonzero index");

    // empty table means zero total
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY
            |-> m_axis_tdata[IDX_W +: SUM_W] == '0)
        else $error("empty status with nonzero total");

endmodule

bind weighted_volume_selector wvs_checker u_wvs_checker (.*);

// ----- tb/tb_weighted_volume_selector.sv -----
// testbench for the weighted volume selector: directed and random add and pick traffic
module tb_weighted_volume_selector;
    import wvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [SUM_W-1:0] total;
    } t_selection;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // weight, rand_frac
    logic [0:0]             s_axis_tuser = '0;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // entry_index, total_weight, zero pad
    logic [1:0]             m_axis_tuser;        // status

    // model of the table, updated at each accepted input transfer
    logic [WEIGHT_BITS-1:0] model_weights [MAX_ENTRIES];
    int unsigned            model_count = 0;
    logic [SUM_W-1:0]       model_total = '0;

    t_selection selection_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_active = 1'b0;
    event start_hold;

    int error_count = 0;
    int results_checked = 0;
    int n_added = 0;
    int n_full = 0;
    int n_picked = 0;
    int n_empty = 0;
    int quiet_cycles = 0;

    weighted_volume_selector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_selection predict_selection(input logic req,
                                                     input logic [WEIGHT_BITS-1:0] w,
                                                     input logic [RAND_BITS-1:0] frac);
        t_selection             r;
        logic [PROD_W-1:0]      prod;
        logic [SUM_W-1:0]       selector;
        logic [SUM_W:0]         accum;
        logic [SUM_W:0]         new_total;
        bit                     found;
        r.status = ST_OK;
        r.index = '0;
        if (req == REQ_ADD) begin
            if (model_count >= MAX_ENTRIES) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                model_weights[model_count] = w;
                r.index = IDX_W'(model_count);
                model_count++;
                new_total = {1'b0, model_total} + (SUM_W+1)'(w);
                model_total = new_total[SUM_W] ? '1 : new_total[SUM_W-1:0];
                n_added++;
            end
        end else if (model_count == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
        end else begin
            n_picked++;
            if (model_count > 1) begin
                prod = PROD_W'(model_total) * PROD_W'(frac);
                selector = prod[PROD_W-1:RAND_BITS];
                accum = '0;
                found = 1'b0;
                // all zero weights fall through to the last stored entry
                r.index = IDX_W'(model_count - 1);
                for (int i = 0; i < model_count; i++) begin
                    accum += (SUM_W+1)'(model_weights[i]);
                    if (!found && {1'b0, selector} < accum) begin
                        r.index = IDX_W'(i);
                        found = 1'b1;
                    end
                end
            end
        end
        r.total = model_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input logic req, input logic [WEIGHT_BITS-1:0] w,
                                input logic [RAND_BITS-1:0] frac);
        t_selection r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= IN_TDATA_W'({$urandom, $urandom});
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {frac, w};
        s_axis_tuser <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_selection(req, w, frac);
        selection_q = {selection_q, r};
        @(negedge i_clk);
    endtask

    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return WEIGHT_BITS'($urandom_range(15));
            3: return WEIGHT_BITS'($urandom_range(1 << 20));
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [RAND_BITS-1:0] random_frac();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return RAND_BITS'($urandom);
        endcase
    endfunction

    task automatic test_empty_table();
        send_request(REQ_PICK, '1, '1);
        send_request(REQ_PICK, '0, '0);
    endtask

    task automatic test_single_entry();
        send_request(REQ_ADD, '0, '1);
        send_request(REQ_PICK, '1, '1);
        send_request(REQ_PICK, '1, '0);
    endtask

    task automatic test_zero_weights();
        send_request(REQ_ADD, '0, '0);
        send_request(REQ_PICK, '0, 16'h8000);
        send_request(REQ_PICK, '1, '1);
    endtask

    task automatic test_weight_extremes();
        send_request(REQ_ADD, '1, '0);
        send_request(REQ_PICK, '0, '0);
        send_request(REQ_PICK, '0, '1);
        send_request(REQ_ADD, 32'd1, '1);
        send_request(REQ_PICK, '1, '1);
        send_request(REQ_ADD, 32'h8000_0000, 16'h5555);
        send_request(REQ_PICK, 32'h5555_5555, 16'h8000);
        send_request(REQ_PICK, 32'hAAAA_AAAA, 16'h0001);
        send_request(REQ_PICK, '0, 16'hAAAA);
    endtask

    // adds while the table has room, mostly picks, and rejected adds once full
    task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
        int add_pct;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            add_pct = (model_count < MAX_ENTRIES) ? 35 : 8;
            if ($urandom_range(99) < add_pct)
                send_request(REQ_ADD, random_weight(), RAND_BITS'($urandom));
            else
                send_request(REQ_PICK, WEIGHT_BITS'($urandom), random_frac());
        end
    endtask

    // receiver holds off while requests keep coming so the input side stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        -> start_hold;
        for (int k = 0; k < 16; k++)
            send_request(1'($urandom_range(1)), random_weight(), random_frac());
    endtask

    always begin
        @(start_hold);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_selection want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (selection_q.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(m_axis_tdata), '0);
            end else begin
                want = selection_q.pop_front();
                results_checked++;
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[IDX_W-1:0] != want.index)
                    report_mismatch("entry_index", 64'(m_axis_tdata[IDX_W-1:0]),
                                    64'(want.index));
                if (m_axis_tdata[IDX_W+SUM_W-1:IDX_W] != want.total)
                    report_mismatch("total_weight", 64'(m_axis_tdata[IDX_W+SUM_W-1:IDX_W]),
                                    64'(want.total));
                if (m_axis_tdata[OUT_TDATA_W-1:IDX_W+SUM_W] != '0)
                    report_mismatch("tdata pad",
                                    64'(m_axis_tdata[OUT_TDATA_W-1:IDX_W+SUM_W]), '0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results pending",
                         quiet_cycles, selection_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_single_entry();
        test_zero_weights();
        test_weight_extremes();
        test_random_mix(130, 0, 0);
        test_output_backpressure();
        test_random_mix(130, 63, 0);
        test_random_mix(130, 0, 63);
        test_random_mix(130, 32, 32);

        s_axis_tvalid <= 1'b0;
        while (selection_q.size() != 0) @(posedge i_clk);
        repeat (MAX_ENTRIES + 8) @(posedge i_clk);

        $display("covered %0d adds, %0d adds on a full table, %0d picks, %0d picks on empty",
                 n_added, n_full, n_picked, n_empty);
        $display("%0d results checked, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
